// ===== rtl/dcbrm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes of the dual-copy block read mapper.
package dcbrm_pkg;

    localparam int S_DATA_W   = 104;  // word_index, word_value, read_offset, read_size
    localparam int S_USER_W   = 1;    // action
    localparam int M_DATA_W   = 136;  // 129 payload bits padded to whole bytes
    localparam int M_USER_W   = 2;    // status
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 34;   // byte positions and block indices, no wrap

    localparam logic [CFG_IDX_W-1:0] REG_AREA_BASE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_SIZE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_ZERO_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_SPACE_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_MODE   = 3'd5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PAST_END = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [4:0] BLOCK_LOG_RESET = 5'd12;

    typedef struct packed {
        logic [31:0] area_base;
        logic [31:0] area_size;
        logic [31:0] copy_zero_base;
        logic [31:0] copy_space_size;
        logic [4:0]  block_log;
        logic        external_mode;
    } cfg_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLAMP = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_SPAN  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_WALK  = 8'b0010_0000,
        S_FETCH = 8'b0100_0000,
        S_REPLY = 8'b1000_0000
    } state_t;

endpackage

// ===== rtl/dcbrm_bitmap_ram.sv =====
`timescale 1ns / 1ps
// Selection bitmap store: one write port, one read port with registered data.
module dcbrm_bitmap_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);
    import dcbrm_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/dcbrm_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file written through the index/data write channel.
module dcbrm_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dcbrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcbrm_pkg::CFG_DATA_W-1:0] cfg_data,
    output dcbrm_pkg::cfg_t                  cfg
);
    import dcbrm_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.area_base       <= '0;
            cfg_reg.area_size       <= '0;
            cfg_reg.copy_zero_base  <= '0;
            cfg_reg.copy_space_size <= '0;
            cfg_reg.block_log       <= BLOCK_LOG_RESET;
            cfg_reg.external_mode   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_AREA_BASE:       cfg_reg.area_base       <= cfg_data;
                REG_AREA_SIZE:       cfg_reg.area_size       <= cfg_data;
                REG_COPY_ZERO_BASE:  cfg_reg.copy_zero_base  <= cfg_data;
                REG_COPY_SPACE_SIZE: cfg_reg.copy_space_size <= cfg_data;
                REG_BLOCK_LOG:       cfg_reg.block_log       <= cfg_data[4:0];
                REG_EXTERNAL_MODE:   cfg_reg.external_mode   <= cfg_data[0];
                default: ;  // ignore unknown index
            endcase
        end
    end

endmodule

// ===== rtl/dual_copy_block_read_mapper.sv =====
`timescale 1ns / 1ps
// Top level: request sequencer, bitmap walk and result register of the read mapper.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: action; tdata: index, word, offset, size
//  m_      | out | m_tvalid/m_tready  | tuser: status; tdata: command fields; tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// A bitmap load goes from accept through S_REPLY to the result register, a one-result
// read (past end, empty, external) through S_CLAMP and S_REPLY. A split read passes S_CLAMP,
// S_SETUP, S_SPAN and S_CHECK to the first walk step, then takes a walk step per block, one
// more per run and a walk step plus an S_FETCH step per bitmap word fetched from the single
// read port of the bitmap memory. When the request spans more than MAX_RUNS blocks the walk
// runs twice: a counting pass for the run cap, then, unless it overflows, the emitting pass.
// aresetn is synchronous; the bitmap memory is not cleared (no clearing pass).
// A stalled m_tready holds the walk on the run it is about to emit; the next
// beat is accepted while the final result of the previous one still waits.
module dual_copy_block_read_mapper #(
    parameter int BITMAP_WORDS = 256,
    parameter int MAX_RUNS     = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dcbrm_pkg::S_DATA_W-1:0]   s_tdata,  // word_index[7:0], word_value,
                                                       // read_offset, read_size[103:72]
    input  logic [dcbrm_pkg::S_USER_W-1:0]   s_tuser,  // action
    // Result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dcbrm_pkg::M_DATA_W-1:0]   m_tdata,  // storage_offset[31:0], buffer_offset,
                                                       // run_length, copy_used[96],
                                                       // total_size[128:97], zero pad
    output logic [dcbrm_pkg::M_USER_W-1:0]   m_tuser,  // status
    output logic                             m_tlast,  // last
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dcbrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcbrm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dcbrm_pkg::*;

    localparam int WIDX_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CNT_W  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam logic [POS_W-1:0] NBITS = POS_W'(32 * BITMAP_WORDS);

    cfg_t cfg;

    dcbrm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    logic [31:0]       roff_reg, roff_next;
    logic [31:0]       rsize_reg, rsize_next;
    logic [31:0]       tot_reg, tot_next;
    logic [31:0]       copy1_reg, copy1_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]  end_reg, end_next;
    logic [POS_W-1:0]  lastblk_reg, lastblk_next;
    logic [POS_W-1:0]  startblk_reg, startblk_next;
    logic [POS_W-1:0]  blk_reg, blk_next;
    logic [POS_W-1:0]  rstart_reg, rstart_next;
    logic              run_bit_reg, run_bit_next;
    logic              first_reg, first_next;
    logic              emit_reg, emit_next;      // emitting pass, not counting pass
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [WORD_W-1:0] cache_word_reg, cache_word_next;
    logic [WIDX_W-1:0] cache_idx_reg, cache_idx_next;
    logic              cache_ok_reg, cache_ok_next;

    logic [1:0]        rep_status_reg, rep_status_next;
    logic [31:0]       rep_so_reg, rep_so_next;
    logic [31:0]       rep_len_reg, rep_len_next;

    // Result register
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        o_status_reg, o_status_next;
    logic [31:0]       o_so_reg, o_so_next;
    logic [31:0]       o_bo_reg, o_bo_next;
    logic [31:0]       o_len_reg, o_len_next;
    logic              o_copy_reg, o_copy_next;
    logic [31:0]       o_tot_reg, o_tot_next;
    logic              o_last_reg, o_last_next;

    // ---------------------------------------------------------------- bitmap
    logic              s_accept;
    logic [31:0]       wide_idx;
    logic              idx_ok;
    logic              ram_we;
    logic              ram_re;
    logic [WIDX_W-1:0] word_sel;
    logic [WORD_W-1:0] ram_rdata;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign wide_idx = 32'(s_tdata[7:0]);
    assign idx_ok   = wide_idx < 32'(BITMAP_WORDS);
    assign ram_we   = s_accept && (s_tuser[0] == ACT_LOAD) && idx_ok;

    dcbrm_bitmap_ram #(
        .DEPTH (BITMAP_WORDS),
        .AW    (WIDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wide_idx[WIDX_W-1:0]),
        .wr_data (s_tdata[39:8]),
        .rd_en   (ram_re),
        .rd_addr (word_sel),
        .rd_data (ram_rdata)
    );

    // ---------------------------------------------------------------- request math
    logic              past_end;
    logic [32:0]       req_end;
    logic [31:0]       clamp_size;
    logic [32:0]       start_sum;
    logic [POS_W-1:0]  end_sum;
    logic [POS_W-1:0]  end_m1;
    logic [POS_W-1:0]  span;

    assign past_end   = roff_reg > cfg.area_size;
    assign req_end    = {1'b0, roff_reg} + {1'b0, rsize_reg};
    assign clamp_size = (req_end > {1'b0, cfg.area_size}) ? (cfg.area_size - roff_reg)
                                                          : rsize_reg;
    assign start_sum  = {1'b0, cfg.area_base} + {1'b0, roff_reg};
    assign end_sum    = start_reg + POS_W'(tot_reg);
    assign end_m1     = end_reg - POS_W'(1);
    assign span       = lastblk_reg - blk_reg;

    // ---------------------------------------------------------------- walk step
    logic              beyond;     // block past the bitmap reads as copy zero
    logic              hit;
    logic              sbit;
    logic              in_range;   // block may still extend the current run
    logic              to_end;     // current run reaches the end of the request
    logic              need_fetch;
    logic              run_end;
    logic [POS_W-1:0]  blk_pos;
    logic [POS_W-1:0]  stop_pos;
    logic [POS_W-1:0]  bo_full;
    logic [POS_W-1:0]  len_full;
    logic [31:0]       copy_base;
    logic              out_free;

    assign word_sel   = blk_reg[5 +: WIDX_W];
    assign beyond     = blk_reg >= NBITS;
    assign hit        = cache_ok_reg && (cache_idx_reg == word_sel);
    assign sbit       = !beyond && cache_word_reg[~blk_reg[4:0]];
    assign in_range   = !beyond && (blk_reg <= lastblk_reg);
    assign to_end     = (!run_bit_reg && beyond) || (blk_reg > lastblk_reg);
    assign need_fetch = !beyond && !hit && (first_reg || in_range);
    assign run_end    = !first_reg && !need_fetch && !(in_range && (sbit == run_bit_reg));
    assign blk_pos    = blk_reg << cfg.block_log;
    assign stop_pos   = to_end ? end_reg : blk_pos;
    assign bo_full    = rstart_reg - start_reg;
    assign len_full   = stop_pos - rstart_reg;
    assign copy_base  = run_bit_reg ? copy1_reg : cfg.copy_zero_base;
    assign out_free   = !m_valid_reg || m_tready;
    assign ram_re     = (state_reg == S_WALK) && need_fetch;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next      = state_reg;
        roff_next       = roff_reg;
        rsize_next      = rsize_reg;
        tot_next        = tot_reg;
        copy1_next      = copy1_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        lastblk_next    = lastblk_reg;
        startblk_next   = startblk_reg;
        blk_next        = blk_reg;
        rstart_next     = rstart_reg;
        run_bit_next    = run_bit_reg;
        first_next      = first_reg;
        emit_next       = emit_reg;
        cnt_next        = cnt_reg;
        cache_word_next = cache_word_reg;
        cache_idx_next  = cache_idx_reg;
        cache_ok_next   = cache_ok_reg;
        rep_status_next = rep_status_reg;
        rep_so_next     = rep_so_reg;
        rep_len_next    = rep_len_reg;

        m_valid_next  = (m_valid_reg && !m_tready) ? 1'b1 : 1'b0;
        o_status_next = o_status_reg;
        o_so_next     = o_so_reg;
        o_bo_next     = o_bo_reg;
        o_len_next    = o_len_reg;
        o_copy_next   = o_copy_reg;
        o_tot_next    = o_tot_reg;
        o_last_next   = o_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    roff_next       = s_tdata[71:40];
                    rsize_next      = s_tdata[103:72];
                    rep_status_next = ST_OK;
                    rep_so_next     = '0;
                    rep_len_next    = '0;
                    // the bitmap write itself goes out this cycle
                    state_next = (s_tuser[0] == ACT_LOAD) ? S_REPLY : S_CLAMP;
                end
            end
            S_CLAMP: begin
                tot_next   = clamp_size;
                start_next = POS_W'(start_sum);
                if (past_end) begin
                    rep_status_next = ST_PAST_END;
                    state_next      = S_REPLY;
                end else if (cfg.external_mode) begin
                    rep_so_next  = start_sum[31:0];
                    rep_len_next = clamp_size;
                    state_next   = S_REPLY;
                end else if (clamp_size == '0) begin
                    state_next = S_REPLY;
                end else begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                end_next      = end_sum;
                blk_next      = start_reg >> cfg.block_log;
                startblk_next = start_reg >> cfg.block_log;
                rstart_next   = start_reg;
                copy1_next    = cfg.copy_zero_base + cfg.copy_space_size;
                state_next    = S_SPAN;
            end
            S_SPAN: begin
                lastblk_next = end_m1 >> cfg.block_log;
                state_next   = S_CHECK;
            end
            S_CHECK: begin
                // few enough blocks cannot overflow the run cap: skip counting
                emit_next     = span < POS_W'(MAX_RUNS);
                cnt_next      = '0;
                first_next    = 1'b1;
                cache_ok_next = 1'b0;
                state_next    = S_WALK;
            end
            S_WALK: begin
                if (need_fetch) begin
                    cache_idx_next = word_sel;
                    state_next     = S_FETCH;
                end else if (first_reg) begin
                    run_bit_next = sbit;
                    first_next   = 1'b0;
                    blk_next     = blk_reg + POS_W'(1);
                end else if (!run_end) begin
                    blk_next = blk_reg + POS_W'(1);
                end else if (!emit_reg) begin
                    // counting pass
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (to_end) begin
                        emit_next   = 1'b1;
                        blk_next    = startblk_reg;
                        rstart_next = start_reg;
                        first_next  = 1'b1;
                    end else if (cnt_reg == CNT_W'(MAX_RUNS - 1)) begin
                        rep_status_next = ST_OVERFLOW;
                        state_next      = S_REPLY;
                    end else begin
                        rstart_next = stop_pos;
                        first_next  = 1'b1;
                    end
                end else if (out_free) begin
                    // emitting pass: hold here until the result register frees
                    m_valid_next  = 1'b1;
                    o_status_next = ST_OK;
                    o_so_next     = copy_base + rstart_reg[31:0];
                    o_bo_next     = bo_full[31:0];
                    o_len_next    = len_full[31:0];
                    o_copy_next   = run_bit_reg;
                    o_tot_next    = tot_reg;
                    o_last_next   = to_end;
                    rstart_next   = stop_pos;
                    first_next    = 1'b1;
                    if (to_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FETCH: begin
                cache_word_next = ram_rdata;
                cache_ok_next   = 1'b1;
                state_next      = S_WALK;
            end
            S_REPLY: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_status_next = rep_status_reg;
                    o_so_next     = rep_so_reg;
                    o_bo_next     = '0;
                    o_len_next    = rep_len_reg;
                    o_copy_next   = 1'b0;
                    o_tot_next    = rep_len_reg;
                    o_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            cache_ok_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            cache_ok_reg <= cache_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        roff_reg       <= roff_next;
        rsize_reg      <= rsize_next;
        tot_reg        <= tot_next;
        copy1_reg      <= copy1_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        lastblk_reg    <= lastblk_next;
        startblk_reg   <= startblk_next;
        blk_reg        <= blk_next;
        rstart_reg     <= rstart_next;
        run_bit_reg    <= run_bit_next;
        first_reg      <= first_next;
        emit_reg       <= emit_next;
        cnt_reg        <= cnt_next;
        cache_word_reg <= cache_word_next;
        cache_idx_reg  <= cache_idx_next;
        rep_status_reg <= rep_status_next;
        rep_so_reg     <= rep_so_next;
        rep_len_reg    <= rep_len_next;
        o_status_reg   <= o_status_next;
        o_so_reg       <= o_so_next;
        o_bo_reg       <= o_bo_next;
        o_len_reg      <= o_len_next;
        o_copy_reg     <= o_copy_next;
        o_tot_reg      <= o_tot_next;
        o_last_reg     <= o_last_next;
    end

    // ---------------------------------------------------------------- result port
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, o_tot_reg, o_copy_reg, o_len_reg, o_bo_reg, o_so_reg};
    assign m_tuser  = o_status_reg;
    assign m_tlast  = o_last_reg;

endmodule

// ===== rtl/dcbrm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the read mapper and its bind to the top level.
module dcbrm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dcbrm_pkg::M_DATA_W-1:0]   m_tdata,
    input logic [dcbrm_pkg::M_USER_W-1:0]   m_tuser,
    input logic                             m_tlast
);
    import dcbrm_pkg::*;

    // an error or overflow result stands alone and carries no command
    a_err_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tlast && m_tdata[95:64] == '0
                                            && !m_tdata[96]))
        else $error("error result is not a lone empty beat");

    // a command never reads more than the clamped request
    a_len_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_OK) |-> (m_tdata[128:97] >= m_tdata[95:64]))
        else $error("run length exceeds total size");

    // while runs of a request are still due, no new request is taken
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |-> !s_tready)
        else $error("input accepted in the middle of a run sequence");

    // hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                      && $stable(m_tlast)))
        else $error("stalled result beat changed");

endmodule

bind dual_copy_block_read_mapper dcbrm_checker u_dcbrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
